FILE: rtl/fcsg_pkg.sv
// Shared types, constants and the control program of the filled circle span generator.
`default_nettype none

package fcsg_pkg;

  localparam int COORD_BITS  = 10;
  localparam int RADIUS_BITS = 7;
  localparam int OUT_BITS    = 12;
  localparam int MAX_RADIUS  = 88;
  localparam int MAX_STEPS   = 64;
  localparam int STEP_BITS   = 7;   // holds 0..MAX_STEPS
  localparam int ROW_BITS    = 8;   // signed, holds -1..MAX_RADIUS
  localparam int DEC_BITS    = 11;  // signed decision value
  localparam int PC_BITS     = 2;

  typedef struct packed {
    logic [COORD_BITS-1:0]  center_col;
    logic [COORD_BITS-1:0]  center_row;
    logic [RADIUS_BITS-1:0] radius;
  } circle_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] near_left;
    logic signed [OUT_BITS-1:0] near_right;
    logic signed [OUT_BITS-1:0] near_row_low;
    logic signed [OUT_BITS-1:0] near_row_high;
    logic signed [OUT_BITS-1:0] wide_left;
    logic signed [OUT_BITS-1:0] wide_right;
    logic signed [OUT_BITS-1:0] wide_row_low;
    logic signed [OUT_BITS-1:0] wide_row_high;
    logic                       last_step;
  } span_t;

  // Condition a step waits on before it takes effect.
  typedef enum logic [1:0] {
    WAIT_NONE   = 2'd0,
    WAIT_CIRCLE = 2'd1,
    WAIT_SLOT   = 2'd2
  } wait_sel_t;

  // Branch taken once the step takes effect; otherwise fall through to pc + 1.
  typedef enum logic [1:0] {
    BR_NEXT   = 2'd0,
    BR_ALWAYS = 2'd1,
    BR_MORE   = 2'd2
  } branch_sel_t;

  typedef struct packed {
    logic               take_circle;
    logic               emit;
    wait_sel_t          wait_sel;
    branch_sel_t        branch_sel;
    logic [PC_BITS-1:0] target;
  } ctrl_word_t;

  // Datapath strobes, issued only in a cycle where the step takes effect.
  typedef struct packed {
    logic load;
    logic emit;
  } dp_ctrl_t;

  typedef struct packed {
    logic slot_free;
    logic more;
  } dp_status_t;

  localparam logic [PC_BITS-1:0] PC_FETCH = 2'd0;
  localparam logic [PC_BITS-1:0] PC_WALK  = 2'd1;
  localparam logic [PC_BITS-1:0] PC_DONE  = 2'd2;

  function automatic ctrl_word_t ucode_word(input logic [PC_BITS-1:0] pc);
    ctrl_word_t w;
    w = '{take_circle: 1'b0, emit: 1'b0, wait_sel: WAIT_NONE,
          branch_sel: BR_ALWAYS, target: PC_FETCH};
    case (pc)
      PC_FETCH: begin
        w.take_circle = 1'b1;
        w.wait_sel    = WAIT_CIRCLE;
        w.branch_sel  = BR_NEXT;
      end
      PC_WALK: begin
        w.emit       = 1'b1;
        w.wait_sel   = WAIT_SLOT;
        w.branch_sel = BR_MORE;
        w.target     = PC_WALK;
      end
      PC_DONE: begin
        w.branch_sel = BR_ALWAYS;
        w.target     = PC_FETCH;
      end
      default: begin
        w.branch_sel = BR_ALWAYS;
        w.target     = PC_FETCH;
      end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/fcsg_sequencer.sv
// Microcode sequencer: step counter, control word fetch and conditional jumps.
`default_nettype none

module fcsg_sequencer
  import fcsg_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       circle_valid,
  input  wire dp_status_t status,
  output logic            circle_ready,
  output dp_ctrl_t        ctrl
);

  logic [PC_BITS-1:0] pc;
  logic [PC_BITS-1:0] pc_next;
  ctrl_word_t         word;
  logic               go;
  logic               taken;

  assign word = ucode_word(pc);

  always_comb begin
    case (word.wait_sel)
      WAIT_NONE:   go = 1'b1;
      WAIT_CIRCLE: go = circle_valid;
      WAIT_SLOT:   go = status.slot_free;
      default:     go = 1'b1;
    endcase
  end

  always_comb begin
    case (word.branch_sel)
      BR_NEXT:   taken = 1'b0;
      BR_ALWAYS: taken = 1'b1;
      BR_MORE:   taken = status.more;
      default:   taken = 1'b1;
    endcase
  end

  always_comb begin
    if (!go) begin
      pc_next = pc;
    end else if (taken) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

  assign circle_ready = word.take_circle;
  assign ctrl.load    = word.take_circle & go;
  assign ctrl.emit    = word.emit & go;

endmodule

`default_nettype wire

FILE: rtl/fcsg_datapath.sv
// Circle walk datapath: loop registers, span arithmetic and the output register.
`default_nettype none

module fcsg_datapath
  import fcsg_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire circle_t  circle,
  input  wire dp_ctrl_t ctrl,
  input  wire logic     span_ready,
  output dp_status_t    status,
  output logic          span_valid,
  output span_t         span
);

  logic [COORD_BITS-1:0]      held_center_col;
  logic [COORD_BITS-1:0]      held_center_row;
  logic [STEP_BITS-1:0]       step_x;
  logic signed [ROW_BITS-1:0] step_y;
  logic signed [DEC_BITS-1:0] decision;

  logic [RADIUS_BITS-1:0]     radius_sat;
  logic [STEP_BITS-1:0]       step_x_next;
  logic signed [ROW_BITS-1:0] step_y_next;
  logic signed [DEC_BITS-1:0] decision_next;
  logic signed [DEC_BITS-1:0] x_dec;
  logic signed [DEC_BITS-1:0] y_dec;
  logic signed [OUT_BITS-1:0] col_w;
  logic signed [OUT_BITS-1:0] row_w;
  logic signed [OUT_BITS-1:0] x_w;
  logic signed [OUT_BITS-1:0] y_w;
  logic                       last;
  span_t                      span_next;

  // Saturate the radius.
  assign radius_sat = (circle.radius > RADIUS_BITS'(MAX_RADIUS))
                      ? RADIUS_BITS'(MAX_RADIUS) : circle.radius;

  assign x_dec = DEC_BITS'(step_x);
  assign y_dec = DEC_BITS'(step_y);

  always_comb begin
    step_x_next = step_x + 1'b1;
    if (decision < 0) begin
      decision_next = decision + (x_dec <<< 2) + DEC_BITS'(6);
      step_y_next   = step_y;
    end else begin
      decision_next = decision + ((x_dec - y_dec) <<< 2) + DEC_BITS'(10);
      step_y_next   = step_y - 1'b1;
    end
  end

  assign last = ($signed({1'b0, step_x_next}) > step_y_next) ||
                (step_x_next == STEP_BITS'(MAX_STEPS));

  assign col_w = $signed({{(OUT_BITS-COORD_BITS){1'b0}}, held_center_col});
  assign row_w = $signed({{(OUT_BITS-COORD_BITS){1'b0}}, held_center_row});
  assign x_w   = $signed({{(OUT_BITS-STEP_BITS){1'b0}}, step_x});
  assign y_w   = {{(OUT_BITS-ROW_BITS){step_y[ROW_BITS-1]}}, step_y};

  always_comb begin
    span_next.near_left     = col_w - x_w;
    span_next.near_right    = col_w + x_w;
    span_next.near_row_low  = row_w - y_w;
    span_next.near_row_high = row_w + y_w;
    span_next.wide_left     = col_w - y_w;
    span_next.wide_right    = col_w + y_w;
    span_next.wide_row_low  = row_w - x_w;
    span_next.wide_row_high = row_w + x_w;
    span_next.last_step     = last;
  end

  // Loop registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_center_col <= '0;
      held_center_row <= '0;
      step_x          <= '0;
      step_y          <= '0;
      decision        <= '0;
    end else if (ctrl.load) begin
      held_center_col <= circle.center_col;
      held_center_row <= circle.center_row;
      step_x          <= '0;
      step_y          <= $signed({1'b0, radius_sat});
      decision        <= DEC_BITS'(3) - (DEC_BITS'(radius_sat) <<< 1);
    end else if (ctrl.emit) begin
      step_x          <= step_x_next;
      step_y          <= step_y_next;
      decision        <= decision_next;
    end
  end

  // Output register: load on emit, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (ctrl.emit) begin
      span_valid <= 1'b1;
    end else if (span_ready) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      span <= span_next;
    end
  end

  assign status.slot_free = !span_valid || span_ready;
  assign status.more      = !last;

endmodule

`default_nettype wire

FILE: rtl/filled_circle_span_generator.sv
// Top level of the filled circle span generator.
`default_nettype none

// Takes one circle transaction (center column, center row, radius) and walks
// the Bresenham circle loop, giving one span transaction per loop step: the
// narrow spans on rows center_row -/+ y over columns center_col -/+ x, and the
// wide spans on rows center_row -/+ x over columns center_col -/+ y. The last
// span transaction of a circle carries last_step. Radii above 88 saturate to
// 88; radius zero gives a single point. Columns and rows are signed 12-bit and
// may fall off the screen: the consumer clips. A circle of radius r gives
// about r/sqrt(2) + 1 span transactions, at most 63 (radius 88). The
// microcode program accepts a circle in PC_FETCH, issues one span per cycle
// in PC_WALK while the output register is free, and returns through PC_DONE
// before it fetches the next circle.
// A new circle is accepted only after the previous one has issued its last
// span; that last span may still sit in the output register meanwhile.

module filled_circle_span_generator
  import fcsg_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    circle_valid,
  output logic         circle_ready,
  input  wire circle_t circle,
  output logic         span_valid,
  input  wire logic    span_ready,
  output span_t        span
);

  dp_ctrl_t   ctrl;
  dp_status_t status;

  // Hold the program counter and issue strobes.
  fcsg_sequencer u_sequencer (
    .clk          (clk),
    .rst          (rst),
    .circle_valid (circle_valid),
    .status       (status),
    .circle_ready (circle_ready),
    .ctrl         (ctrl)
  );

  // Advance the circle walk and register each span.
  fcsg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .circle     (circle),
    .ctrl       (ctrl),
    .span_ready (span_ready),
    .status     (status),
    .span_valid (span_valid),
    .span       (span)
  );

endmodule

`default_nettype wire

FILE: rtl/fcsg_checker.sv
// Port-level checks of the filled circle span generator, bound to the top level.
`default_nettype none

module fcsg_checker
  import fcsg_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    circle_valid,
  input wire logic    circle_ready,
  input wire circle_t circle,
  input wire logic    span_valid,
  input wire logic    span_ready,
  input wire span_t   span
);

  // A waiting circle transaction holds.
  a_circle_hold: assert property (@(posedge clk) disable iff (rst)
    circle_valid && !circle_ready |=> circle_valid && $stable(circle))
    else $error("waiting circle changed or dropped");

  // A stalled span transaction holds.
  a_span_hold: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_ready |=> span_valid && $stable(span))
    else $error("stalled span changed or dropped");

  // Block stays busy right after taking a circle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    circle_valid && circle_ready |=> !circle_ready)
    else $error("circle accepted twice in a row");

  // A new circle is taken only once the previous walk issued its last span.
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    circle_ready && span_valid |-> span.last_step)
    else $error("ready while a circle is still in progress");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (
  .clk          (clk),
  .rst          (rst),
  .circle_valid (circle_valid),
  .circle_ready (circle_ready),
  .circle       (circle),
  .span_valid   (span_valid),
  .span_ready   (span_ready),
  .span         (span)
);

`default_nettype wire
